// ===== rtl/ltc_pkg.sv =====
`default_nettype none
package ltc_pkg;

  localparam int CACHE_ENTRIES = 128;
  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int SLOT_W = 7;
  localparam int OCC_W = 8;
  localparam int COLOR_W = 32;
  localparam int WIDTH_W = 64;
  localparam int TAG_W = COLOR_W + WIDTH_W;
  localparam int STAMP_W = 64;

  typedef struct packed {
    logic [COLOR_W-1:0] color_key;
    logic [WIDTH_W-1:0] width_key;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             vld;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] min_idx;
  } scan_sts_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[OCC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lru_tag_cache_lookup.sv =====
`default_nettype none
// Sequence: start moves the FSM to SCAN, which reads every resident entry, then DRAIN and FINISH;
// when empty it goes to FINISH at once. One read of the tag and stamp memories a cycle.
// Throughput: one word at a time; the next start is taken the cycle done is high.
// Reset: synchronous; empties the directory and zeroes the use clock.
// The receiver cannot stall: each result is on rsp for the one cycle done is high.
module lru_tag_cache_lookup
  import ltc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  state_t             state, state_next;
  logic [TAG_W-1:0]   key;
  logic [STAMP_W-1:0] use_clock;
  logic [CNT_W-1:0]   entry_count;
  logic [IDX_W-1:0]   rd_idx;
  logic               d_vld;
  logic [IDX_W-1:0]   d_idx;

  logic               accept;
  logic               issue;
  logic               last_issue;
  logic               full;
  logic               finish;
  logic [IDX_W-1:0]   where_idx;
  logic [CNT_W-1:0]   count_next;
  logic               tag_we;

  logic [TAG_W-1:0]   tag_rd;
  logic [STAMP_W-1:0] stamp_rd;
  scan_ctl_t          scan_ctl;
  scan_sts_t          scan_sts;

  assign full       = entry_count == CNT_W'(CACHE_ENTRIES);
  assign last_issue = CNT_W'(rd_idx) == entry_count - CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (entry_count == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    issue  = 1'b0;
    finish = 1'b0;
    case (state)
      ST_IDLE:   busy   = 1'b0;
      ST_SCAN:   issue  = 1'b1;
      ST_DRAIN:  busy   = 1'b1;
      ST_FINISH: finish = 1'b1;
      default:   busy   = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_comb begin
    count_next = entry_count;
    where_idx  = scan_sts.hit_idx;
    if (!scan_sts.hit) begin
      if (full) begin
        where_idx = scan_sts.min_idx;
      end else begin
        where_idx  = entry_count[IDX_W-1:0];
        count_next = entry_count + CNT_W'(1);
      end
    end
  end

  assign tag_we = finish && !scan_sts.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      use_clock   <= '0;
      entry_count <= '0;
      rd_idx      <= '0;
      d_vld       <= 1'b0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      d_vld <= issue;
      done  <= finish;
      if (accept) begin
        use_clock <= use_clock + STAMP_W'(1);
        rd_idx    <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (finish) begin
        entry_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_idx <= rd_idx;
    if (accept) begin
      key <= {req.color_key, req.width_key};
    end
    if (finish) begin
      rsp.hit       <= scan_sts.hit;
      rsp.slot      <= to_slot(where_idx);
      rsp.evicted   <= !scan_sts.hit && full;
      rsp.occupancy <= to_occ(count_next);
    end
  end

  assign scan_ctl.clear = accept;
  assign scan_ctl.vld   = d_vld;
  assign scan_ctl.idx   = d_idx;

  ltc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (where_idx),
    .wdata (key),
    .raddr (rd_idx),
    .rdata (tag_rd)
  );

  ltc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (finish),
    .waddr (where_idx),
    .wdata (use_clock),
    .raddr (rd_idx),
    .rdata (stamp_rd)
  );

  ltc_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .key      (key),
    .tag_rd   (tag_rd),
    .stamp_rd (stamp_rd),
    .sts      (scan_sts)
  );

endmodule
`default_nettype wire

// ===== rtl/ltc_ram.sv =====
`default_nettype none
module ltc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ltc_scan.sv =====
`default_nettype none
module ltc_scan
  import ltc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scan_ctl_t          ctl,
  input  wire logic [TAG_W-1:0]   key,
  input  wire logic [TAG_W-1:0]   tag_rd,
  input  wire logic [STAMP_W-1:0] stamp_rd,
  output scan_sts_t               sts
);

  logic               hit;
  logic               first;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   min_idx;
  logic [STAMP_W-1:0] best;

  // first match wins; strict less-than keeps the lowest slot on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      hit   <= 1'b0;
      first <= 1'b1;
    end else if (ctl.clear) begin
      hit   <= 1'b0;
      first <= 1'b1;
    end else if (ctl.vld) begin
      if (!hit && tag_rd == key) begin
        hit     <= 1'b1;
        hit_idx <= ctl.idx;
      end
      if (first || stamp_rd < best) begin
        best    <= stamp_rd;
        min_idx <= ctl.idx;
        first   <= 1'b0;
      end
    end
  end

  assign sts.hit     = hit;
  assign sts.hit_idx = hit_idx;
  assign sts.min_idx = min_idx;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import ltc_pkg::*;

  localparam int RANDOM_WORDS = 1450;
  localparam int POOL_SIZE = 224;
  localparam int HOT_SIZE = 32;
  localparam int WATCHDOG = 5000;
  localparam int SETTLE_CYCLES = CACHE_ENTRIES + 16;

  class lru_shadow;
    bit                 valid [CACHE_ENTRIES];
    logic [COLOR_W-1:0] tag_c [CACHE_ENTRIES];
    logic [WIDTH_W-1:0] tag_w [CACHE_ENTRIES];
    logic [STAMP_W-1:0] stamp [CACHE_ENTRIES];
    logic [STAMP_W-1:0] use_clk;
    int                 count;
    rsp_t               pending_rsp[$];
    int                 errors;

    function new();
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        valid[i] = 1'b0;
      end
      use_clk = '0;
      count = 0;
      errors = 0;
    endfunction

    function rsp_t predict_lookup(req_t w);
      rsp_t               r;
      logic [31:0]        where;
      bit                 found;
      bit                 have_free;
      bit                 replaced;
      logic [STAMP_W-1:0] oldest;
      where = '0;
      found = 1'b0;
      have_free = 1'b0;
      replaced = 1'b0;
      use_clk = use_clk + 1'b1;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (!found && valid[i] && tag_c[i] == w.color_key && tag_w[i] == w.width_key) begin
          where = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (!have_free && !valid[i]) begin
            where = i;
            have_free = 1'b1;
          end
        end
        if (have_free) begin
          count++;
        end else begin
          // strict less-than keeps the lowest slot on equal stamps
          oldest = stamp[0];
          where = 0;
          for (int i = 1; i < CACHE_ENTRIES; i++) begin
            if (stamp[i] < oldest) begin
              oldest = stamp[i];
              where = i;
            end
          end
          replaced = 1'b1;
        end
        valid[where] = 1'b1;
        tag_c[where] = w.color_key;
        tag_w[where] = w.width_key;
      end
      stamp[where] = use_clk;
      r.hit = found;
      r.slot = where[SLOT_W-1:0];
      r.evicted = replaced;
      r.occupancy = count[OCC_W-1:0];
      return r;
    endfunction

    function void note_lookup(req_t w);
      pending_rsp.push_back(predict_lookup(w));
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $error("result word with no lookup outstanding");
        errors++;
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.slot !== exp.slot) begin
        $error("slot: expected %0d, got %0d", exp.slot, got.slot);
        errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $error("evicted: expected %0d, got %0d", exp.evicted, got.evicted);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction
  endclass

  logic clk = 1'b1;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  lru_shadow dir = new();
  req_t      key_pool [POOL_SIZE];
  int        gap_pct;
  int        quiet;

  lru_tag_cache_lookup uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #5 clk = 1'b0;
    #5 clk = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else begin
      if (done) dir.check_result(rsp);
      if (start && !busy) dir.note_lookup(req);
      if (done || (start && !busy)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  function automatic req_t fresh_key();
    req_t k;
    k.color_key = $urandom;
    k.width_key = {$urandom, $urandom};
    return k;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(req_t w);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pair(logic [COLOR_W-1:0] c, logic [WIDTH_W-1:0] wk);
    req_t k;
    k.color_key = c;
    k.width_key = wk;
    send_word(k);
  endtask

  task automatic random_word();
    req_t k;
    int   pick;
    int   b;
    pick = $urandom_range(99);
    if (pick < 45) begin
      k = key_pool[$urandom_range(POOL_SIZE-1)];
    end else if (pick < 75) begin
      // hot set keeps recent stamps fresh so the oldest entry is not always a hot key
      k = key_pool[$urandom_range(HOT_SIZE-1)];
    end else if (pick < 90) begin
      // near miss: one bit away from a resident-looking key
      k = key_pool[$urandom_range(POOL_SIZE-1)];
      b = $urandom_range(TAG_W-1);
      k[b] = ~k[b];
    end else begin
      k = fresh_key();
    end
    send_word(k);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    gap_pct = 23;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = fresh_key();
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send_pair('0, '0);
    send_pair('1, '1);
    send_pair('0, '0);
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
    send_pair(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_pair('1, '1);
    send_pair(32'h1, 64'h1);
    send_pair(32'h1, 64'h3);
    send_pair(32'h3, 64'h1);
    send_pair(32'h8000_0000, 64'h8000_0000_0000_0000);
    send_pair(32'h1, 64'h1);
    send_pair('0, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n < RANDOM_WORDS / 3) gap_pct = 23;
      else if (n < 2 * RANDOM_WORDS / 3) gap_pct = 72;
      else gap_pct = 0;
      random_word();
    end
    start <= 1'b0;

    while (dir.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (dir.errors == 0 && dir.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
